// File: src/gvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_pkg
// Shared types and codes of the grain voice mixer: item layouts, operation
// codes, register indexes, per-grain state word and mixer control.
// ----------------------------------------------------------------------------
package gvm_pkg;

    typedef enum logic [1:0] {
        KIND_CLAIM = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_START = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_GAIN    = 2'd0;
    localparam t_cfg_idx CFG_OVERLAP = 2'd1;

    typedef struct packed {
        t_kind              kind;
        logic [5:0]         slot;
        logic [9:0]         position;
        logic signed [15:0] sample_in;
        logic [15:0]        start_delay;
        logic [10:0]        grain_length;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [5:0]         free_slot;
        logic [16:0]        max_end;
        logic signed [15:0] mix_sample;
    } t_out_item;

    typedef struct packed {
        t_cfg_idx    addr;
        logic [15:0] wdata;
    } t_cfg_item;

    // Per-grain state word kept in the grain state RAM
    typedef struct packed {
        logic [15:0] delay;
        logic [10:0] len;
        logic [10:0] rpos;
    } t_meta;

    typedef struct packed {
        logic clr;
        logic mul_en;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
    } t_mac_sts;

endpackage

// File: src/gvm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_ifs
// Valid/ready channel interfaces for input items, result items and register
// writes of the grain voice mixer.
// ----------------------------------------------------------------------------
interface gvm_in_if import gvm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gvm_out_if import gvm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gvm_cfg_if import gvm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/gvm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/gvm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_mac
// Shared multiply-accumulate unit: registered sample-times-gain product,
// wide accumulator, round-to-nearest by 4096 and saturation to 16 bits.
// ----------------------------------------------------------------------------
module gvm_mac import gvm_pkg::*; #(
    parameter int NUM_TERMS = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_ctl           i_ctl,
    input  logic signed [15:0] i_sample,
    input  logic [15:0]        i_gain,
    output t_mac_sts           o_sts,
    output logic signed [15:0] o_mix
);

    localparam int ACC_W = 33 + $clog2(NUM_TERMS + 1);
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(2048);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    logic signed [32:0]      w_prod;
    logic signed [32:0]      r_prod;
    logic                    r_prod_vld;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [ACC_W-1:0] w_q;

    assign w_prod = $signed({1'b0, i_gain}) * i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.mul_en;
        end
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // floor((acc + 2048) / 4096), then clamp
    assign w_rnd = r_acc + RND;
    assign w_q   = w_rnd >>> 12;

    always_comb begin
        priority if (w_q > SAT_HI) begin
            o_mix = 16'sh7fff;
        end else if (w_q < SAT_LO) begin
            o_mix = -16'sh8000;
        end else begin
            o_mix = 16'(w_q);
        end
    end

    assign o_sts.busy = r_prod_vld;

endmodule

// File: src/grain_voice_mixer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grain_voice_mixer_core
// Granular synthesis grain pool and mixer. Claims, sample writes, grain
// starts and per-sample mix ticks over a pool of NUM_GRAINS grains.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Moves                                  Accepted when
//  --------  ---  -------------------------------------  -----------------
//  i_in      in   claim / write / start / tick items     valid & ready
//  o_res     out  one result per item                    valid & ready
//  i_cfg     in   register writes: gain, overlap         valid & ready
//
//  Write and start items pass from the execute state to the done state.
//  Claim and tick items walk the grains one per cycle through the grain
//  state RAM; tick samples go through the one shared multiply-accumulate
//  unit, which the sequencer lets drain before finishing.
//  Reset clears the play flags and the grain state valid bits at once; the
//  sample store has no reset and needs no clearing pass.
//  The input is taken again while a result waits in the output register; a
//  finished item holds in the done state until that register is free.
//  The register port is always ready.
//
module grain_voice_mixer_core import gvm_pkg::*; #(
    parameter int NUM_GRAINS    = 40,
    parameter int GRAIN_SAMPLES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gvm_in_if.sink    i_in,
    gvm_out_if.source o_res,
    gvm_cfg_if.sink   i_cfg
);

    localparam int GW     = (NUM_GRAINS > 1) ? $clog2(NUM_GRAINS) : 1;
    localparam int CW     = $clog2(NUM_GRAINS + 1);
    localparam int SDEPTH = NUM_GRAINS * GRAIN_SAMPLES;
    localparam int SW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int META_W = $bits(t_meta);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    t_in_item    r_item;
    logic [15:0] r_gain;
    logic [10:0] r_overlap;

    logic r_play [NUM_GRAINS];
    logic r_mvld [NUM_GRAINS];

    logic [CW-1:0] r_cnt;
    logic          r_s1_vld;
    logic [GW-1:0] r_s1_idx;
    logic          r_s2_vld;

    logic [16:0] r_best;
    logic        r_found;
    logic [5:0]  r_free;

    t_out_item r_out;
    logic      r_out_vld;

    // Item decode
    logic          w_accept;
    logic          w_slot_ok;
    logic          w_pos_ok;
    logic [GW-1:0] w_slot_idx;
    logic          w_is_tick;
    logic          w_is_claim;
    logic          w_issue;
    logic          w_out_free;

    // Grain state RAM
    logic [META_W-1:0] w_meta_rdata;
    logic              w_meta_we;
    logic [GW-1:0]     w_meta_waddr;
    t_meta             w_meta_wdata;

    // Sample store
    logic          w_st_we;
    logic [SW-1:0] w_st_waddr;
    logic          w_st_re;
    logic [SW-1:0] w_st_raddr;
    logic [15:0]   w_st_rdata;

    // Scan stage one
    t_meta       w_meta;
    logic        w_play;
    logic        w_wait;
    logic        w_take;
    logic [10:0] w_rp_n;
    logic        w_stop;
    logic        w_upd;
    logic [16:0] w_sum;
    logic [16:0] w_end;

    t_mac_ctl           w_mac_ctl;
    t_mac_sts           w_mac_sts;
    logic signed [15:0] w_mix;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_slot_ok  = 32'(r_item.slot) < NUM_GRAINS;
    assign w_pos_ok   = 32'(r_item.position) < GRAIN_SAMPLES;
    assign w_slot_idx = r_item.slot[GW-1:0];
    assign w_is_tick  = r_item.kind == KIND_TICK;
    assign w_is_claim = r_item.kind == KIND_CLAIM;
    assign w_issue    = (r_state == S_SCAN) && (r_cnt < CW'(NUM_GRAINS));
    assign w_out_free = !r_out_vld || o_res.ready;

    // ------------------------------------------------------------------
    // Scan stage one: grain state word of r_s1_idx is on the RAM output.
    // A grain never started reads as all zero.
    // ------------------------------------------------------------------
    always_comb begin
        w_meta = r_mvld[r_s1_idx] ? t_meta'(w_meta_rdata) : '0;
        w_play = r_play[r_s1_idx];
        w_wait = w_meta.delay != '0;
        w_take = !w_wait && (w_meta.rpos < w_meta.len);
        w_rp_n = w_take ? w_meta.rpos + 11'd1 : w_meta.rpos;
        w_stop = !w_wait && (w_rp_n >= w_meta.len);
        w_upd  = r_s1_vld && w_is_tick && w_play;
        w_sum  = 17'(w_meta.delay) + 17'(w_meta.len);
        w_end  = (w_sum > 17'(r_overlap)) ? w_sum - 17'(r_overlap) : '0;
    end

    // Grain state writes: arm on start, count down or advance on tick
    always_comb begin
        w_meta_we    = 1'b0;
        w_meta_waddr = r_s1_idx;
        w_meta_wdata = w_meta;
        if (r_state == S_EXEC && r_item.kind == KIND_START && w_slot_ok) begin
            w_meta_we          = 1'b1;
            w_meta_waddr       = w_slot_idx;
            w_meta_wdata.delay = r_item.start_delay;
            w_meta_wdata.len   = (32'(r_item.grain_length) > GRAIN_SAMPLES) ?
                                 11'(GRAIN_SAMPLES) : r_item.grain_length;
            w_meta_wdata.rpos  = '0;
        end else if (w_upd && (w_wait || w_take)) begin
            w_meta_we          = 1'b1;
            w_meta_wdata.delay = w_wait ? w_meta.delay - 16'd1 : w_meta.delay;
            w_meta_wdata.rpos  = w_rp_n;
        end
    end

    assign w_st_we    = (r_state == S_EXEC) && (r_item.kind == KIND_WRITE) &&
                        w_slot_ok && w_pos_ok;
    assign w_st_waddr = SW'(32'(r_item.slot) * GRAIN_SAMPLES + 32'(r_item.position));
    assign w_st_re    = w_upd && w_take;
    assign w_st_raddr = SW'(32'(r_s1_idx) * GRAIN_SAMPLES + 32'(w_meta.rpos));

    assign w_mac_ctl.clr    = w_accept;
    assign w_mac_ctl.mul_en = r_s2_vld;

    gvm_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_GRAINS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (w_meta_wdata),
        .i_re    (w_issue),
        .i_raddr (r_cnt[GW-1:0]),
        .o_rdata (w_meta_rdata)
    );

    gvm_ram #(
        .WIDTH (16),
        .DEPTH (SDEPTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (r_item.sample_in),
        .i_re    (w_st_re),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    gvm_mac #(
        .NUM_TERMS (NUM_GRAINS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_sample (w_st_rdata),
        .i_gain   (r_gain),
        .o_sts    (w_mac_sts),
        .o_mix    (w_mix)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.data.kind == KIND_CLAIM || i_in.data.kind == KIND_TICK) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                // last grain issued: let the pipeline drain
                if (!w_issue) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!r_s1_vld && !r_s2_vld && !w_mac_sts.busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gain    <= '0;
            r_overlap <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
            for (int g = 0; g < NUM_GRAINS; g++) begin
                r_play[g] <= 1'b0;
                r_mvld[g] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_s1_vld <= w_issue;
            r_s1_idx <= r_cnt[GW-1:0];
            r_s2_vld <= w_st_re;

            if (i_cfg.valid) begin
                if (i_cfg.data.addr == CFG_GAIN) begin
                    r_gain <= i_cfg.data.wdata;
                end else if (i_cfg.data.addr == CFG_OVERLAP) begin
                    r_overlap <= i_cfg.data.wdata[10:0];
                end
            end

            if (w_accept) begin
                r_item  <= i_in.data;
                r_cnt   <= '0;
                r_best  <= '0;
                r_found <= 1'b0;
                r_free  <= '0;
            end else if (w_issue) begin
                r_cnt <= r_cnt + CW'(1);
            end

            // arm a grain
            if (r_state == S_EXEC && r_item.kind == KIND_START && w_slot_ok) begin
                r_play[w_slot_idx] <= 1'b1;
                r_mvld[w_slot_idx] <= 1'b1;
            end

            // drop a grain that ran out of samples
            if (w_upd && w_stop) begin
                r_play[r_s1_idx] <= 1'b0;
            end

            // claim: track largest end and first idle grain
            if (r_s1_vld && w_is_claim) begin
                if (w_end > r_best) begin
                    r_best <= w_end;
                end
                if (!r_found && !w_play) begin
                    r_found <= 1'b1;
                    r_free  <= 6'(r_s1_idx);
                end
            end

            if (r_state == S_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end

        // Result register: payload only
        if (r_state == S_DONE && w_out_free) begin
            if (w_is_claim) begin
                r_out <= '{found: r_found, free_slot: r_free, max_end: r_best,
                           mix_sample: '0};
            end else if (w_is_tick) begin
                r_out <= '{found: 1'b0, free_slot: '0, max_end: '0, mix_sample: w_mix};
            end else begin
                r_out <= '0;
            end
        end
    end

    assign i_in.ready  = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

endmodule

// File: src/gvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvm_checker
// Port-level checks of the grain voice mixer, bound to the top level.
// ----------------------------------------------------------------------------
module gvm_checker import gvm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_res_valid,
    input logic      i_res_ready,
    input t_out_item i_res_data
);

    // one item at a time: input closes after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready after accepted transaction");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_no_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_data.found |-> i_res_data.free_slot == 6'd0)
        else $error("free slot reported without idle grain");

    a_claim_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.found |-> i_res_data.mix_sample == 16'sd0)
        else $error("claim result carries a mix sample");

endmodule

bind grain_voice_mixer_core gvm_checker u_gvm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for grain_voice_mixer_core. A queue-fed driver sends
// claim, write, start and tick transactions. A monitor predicts every result
// from a cycle-free model of the grain pool and checks each returned result
// field by field. Phases change gain, overlap and the idle/stall pattern.
// ----------------------------------------------------------------------------
module testbench;
    import gvm_pkg::*;

    localparam int NG         = 40;         // grains in the pool
    localparam int GS         = 1024;       // samples per grain
    localparam int RAND_STEPS = 50;         // random steps per phase
    localparam int LIMIT_NS   = 8_000_000;  // hard stop for a hung run

    typedef enum {
        PACE_STEADY,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } t_pace;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gvm_in_if  grain_in ();
    gvm_out_if grain_res ();
    gvm_cfg_if reg_wr ();

    grain_voice_mixer_core #(
        .NUM_GRAINS   (NG),
        .GRAIN_SAMPLES(GS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (grain_in),
        .o_res  (grain_res),
        .i_cfg  (reg_wr)
    );

    // 4 ns period: high half, then low half
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted state of the grain pool and its two registers
    // ------------------------------------------------------------------------
    shortint     pcm       [NG][GS];
    bit          voice_on  [NG];
    logic [15:0] wait_cnt  [NG];
    logic [10:0] read_idx  [NG];
    logic [10:0] voice_len [NG];
    logic [15:0] mdl_gain;
    logic [10:0] mdl_overlap;

    // Stimulus side: sample slots already loaded, so no start ever plays a
    // sample that was never written
    bit          loaded    [NG][GS];

    t_in_item    item_backlog [$];   // transactions waiting for the driver
    t_out_item   due_results  [$];   // predicted results, oldest first
    bit          in_taken;           // set by the monitor on an input transaction
    int          n_bad;
    t_pace       pace;

    // ------------------------------------------------------------------------
    // Advance the predicted pool by one transaction and return its result.
    // Fields that do not belong to the transaction's kind stay zero.
    // ------------------------------------------------------------------------
    function automatic t_out_item grain_pool_step(t_in_item it);
        t_out_item   res;
        int unsigned span;
        int unsigned longest;
        longint      acc;
        longint      rounded;
        res = '0;
        case (it.kind)
            KIND_CLAIM: begin
                // Max end spans every grain, playing or not
                longest = 0;
                for (int g = 0; g < NG; g++) begin
                    span = wait_cnt[g] + voice_len[g];
                    span = (span > mdl_overlap) ? span - mdl_overlap : 0;
                    if (span > longest) longest = span;
                end
                for (int g = 0; g < NG; g++) begin
                    if (!voice_on[g]) begin
                        res.found     = 1'b1;
                        res.free_slot = 6'(g);
                        break;
                    end
                end
                res.max_end = 17'(longest);
            end
            KIND_WRITE: begin
                if (it.slot < NG) pcm[it.slot][it.position] = it.sample_in;
            end
            KIND_START: begin
                if (it.slot < NG) begin
                    wait_cnt[it.slot]  = it.start_delay;
                    voice_len[it.slot] = (it.grain_length > GS) ? 11'(GS) : it.grain_length;
                    read_idx[it.slot]  = '0;
                    voice_on[it.slot]  = 1'b1;
                end
            end
            KIND_TICK: begin
                acc = 0;
                for (int g = 0; g < NG; g++) begin
                    if (!voice_on[g]) continue;
                    // Count the delay down before the grain sounds
                    if (wait_cnt[g] != 0) begin
                        wait_cnt[g] = wait_cnt[g] - 16'd1;
                        continue;
                    end
                    if (read_idx[g] < voice_len[g]) begin
                        acc += longint'(pcm[g][read_idx[g]]) * longint'(mdl_gain);
                        read_idx[g] = read_idx[g] + 11'd1;
                    end
                    // An empty grain drops out here too, having added nothing
                    if (read_idx[g] >= voice_len[g]) voice_on[g] = 1'b0;
                end
                // Round to nearest, ties upward, then clamp to 16 bits
                rounded = (acc + 2048) >>> 12;
                if (rounded > 32767) rounded = 32767;
                if (rounded < -32768) rounded = -32768;
                res.mix_sample = 16'(rounded);
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------

    // Fill every field with noise, then set the kind; unused fields stay random
    function automatic t_in_item blank_item(t_kind k);
        t_in_item    it;
        logic [63:0] noise;
        noise   = {$urandom, $urandom};
        it      = noise[$bits(t_in_item)-1:0];
        it.kind = k;
        return it;
    endfunction

    function automatic void add_plain(t_kind k);
        item_backlog.push_back(blank_item(k));
    endfunction

    function automatic void add_write(int slot, int pos, logic [15:0] smp);
        t_in_item it;
        it           = blank_item(KIND_WRITE);
        it.slot      = 6'(slot);
        it.position  = 10'(pos);
        it.sample_in = smp;
        if (slot < NG) loaded[slot][pos] = 1'b1;
        item_backlog.push_back(it);
    endfunction

    // Load any missing samples of the grain first, so playback never reads
    // an unwritten entry
    function automatic void add_start(int slot, logic [15:0] dly, logic [10:0] len);
        t_in_item it;
        int       lim;
        if (slot < NG) begin
            lim = (len > GS) ? GS : len;
            for (int p = 0; p < lim; p++)
                if (!loaded[slot][p]) add_write(slot, p, 16'($urandom));
        end
        it              = blank_item(KIND_START);
        it.slot         = 6'(slot);
        it.start_delay  = dly;
        it.grain_length = len;
        item_backlog.push_back(it);
    endfunction

    // One random step: mostly playable voices and ticks, some noise with
    // slots past the pool
    function automatic void add_random_step();
        int          dice;
        int          roll;
        int          slot;
        int          pos;
        logic [15:0] dly;
        logic [10:0] len;
        dice = $urandom_range(99);
        // Favor low slots so the lowest idle grain moves around
        slot = $urandom_range(1) ? $urandom_range(7) : $urandom_range(NG - 1);
        pos  = ($urandom_range(9) < 7) ? $urandom_range(31) : $urandom_range(GS - 1);
        roll = $urandom_range(99);
        dly  = (roll < 70) ? 16'($urandom_range(3)) :
               (roll < 97) ? 16'($urandom_range(40, 4)) : 16'($urandom);
        roll = $urandom_range(99);
        len  = (roll < 10) ? 11'd0 :
               (roll < 85) ? 11'($urandom_range(8, 1)) :
               (roll < 98) ? 11'($urandom_range(24, 9)) : 11'($urandom_range(64, 25));
        if (dice < 34)
            add_plain(KIND_TICK);
        else if (dice < 48)
            add_plain(KIND_CLAIM);
        else if (dice < 70)
            add_write(slot, pos, 16'($urandom));
        else if (dice < 90)
            add_start(slot, dly, len);
        else if (dice < 95)
            add_write($urandom_range(63, NG), $urandom_range(GS - 1), 16'($urandom));
        else
            add_start($urandom_range(63, NG), 16'($urandom), 11'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Pacing, register writes, phase control
    // ------------------------------------------------------------------------
    function automatic bit roll_idle(bit heavy, bit light);
        if (heavy) return $urandom_range(99) < 78;
        if (light) return $urandom_range(99) < 30;
        return 1'b0;
    endfunction

    function automatic void flag_error(string msg);
        n_bad++;
        if (n_bad <= 10) $display("%s", msg);
    endfunction

    // Write one register; track it in the model at the accepting edge
    task automatic set_register(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        reg_wr.valid <= 1'b1;
        reg_wr.data  <= '{addr: idx, wdata: val};
        do @(posedge i_clk); while (!reg_wr.ready);
        case (idx)
            CFG_GAIN:    mdl_gain    = val;
            CFG_OVERLAP: mdl_overlap = val[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        reg_wr.valid <= 1'b0;
    endtask

    // Hold until nothing is queued, in flight or outstanding
    task automatic wait_drained();
        do @(posedge i_clk);
        while (item_backlog.size() != 0 || grain_in.valid || due_results.size() != 0);
    endtask

    task automatic enter_phase(t_pace p, logic [15:0] g, logic [15:0] ovl);
        wait_drained();
        pace = p;
        set_register(CFG_GAIN, g);
        set_register(CFG_OVERLAP, ovl);
    endtask

    // ------------------------------------------------------------------------
    // Driver: drive on the falling edge. Hold valid and data until the
    // monitor saw the transaction; only then fetch the next one or idle.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive
        logic     nxt_valid;
        t_in_item nxt_data;
        nxt_valid = grain_in.valid;
        nxt_data  = grain_in.data;
        if (in_taken) begin
            nxt_valid = 1'b0;
            in_taken  = 1'b0;
        end
        if (!nxt_valid && item_backlog.size() != 0
            && !roll_idle(pace == PACE_SEND_GAPS, pace == PACE_BOTH)) begin
            nxt_data  = item_backlog.pop_front();
            nxt_valid = 1'b1;
        end
        grain_in.valid <= nxt_valid;
        grain_in.data  <= nxt_data;
        grain_res.ready <= !roll_idle(pace == PACE_RECV_STALLS, pace == PACE_BOTH);
    end

    // ------------------------------------------------------------------------
    // Monitor: sample on the rising edge. Check returned results against the
    // oldest prediction, then predict for any input transaction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (i_rst_n) begin
            if (grain_res.valid && grain_res.ready) begin
                if (due_results.size() == 0) begin
                    flag_error($sformatf("unexpected result: %p", grain_res.data));
                end else begin
                    want = due_results.pop_front();
                    if (grain_res.data.found !== want.found
                        || grain_res.data.free_slot !== want.free_slot
                        || grain_res.data.max_end !== want.max_end
                        || grain_res.data.mix_sample !== want.mix_sample)
                        flag_error($sformatf({"result mismatch: expected found=%0d slot=%0d",
                            " end=%0d mix=%0d, got found=%0d slot=%0d end=%0d mix=%0d"},
                            want.found, want.free_slot, want.max_end, want.mix_sample,
                            grain_res.data.found, grain_res.data.free_slot,
                            grain_res.data.max_end, grain_res.data.mix_sample));
                end
            end
            if (grain_in.valid && grain_in.ready) begin
                due_results.push_back(grain_pool_step(grain_in.data));
                in_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed checks, then paced random phases
    // ------------------------------------------------------------------------
    initial begin
        t_in_item parked;
        i_rst_n         = 1'b0;
        grain_in.valid  = 1'b0;
        grain_in.data   = '0;
        grain_res.ready = 1'b0;
        reg_wr.valid    = 1'b0;
        reg_wr.data     = '0;
        pace            = PACE_STEADY;
        in_taken        = 1'b0;
        n_bad           = 0;
        mdl_gain        = '0;
        mdl_overlap     = '0;
        foreach (voice_on[g]) begin
            voice_on[g]  = 1'b0;
            wait_cnt[g]  = '0;
            read_idx[g]  = '0;
            voice_len[g] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty pool, zero gain
        add_plain(KIND_CLAIM);
        add_plain(KIND_TICK);

        // Full gain: clamp both ways, ignored slots, an empty grain, longest delay
        enter_phase(PACE_STEADY, 16'hFFFF, 16'd0);
        add_write(0, 0, 16'sh7FFF);
        add_write(0, 1, 16'sh8000);
        add_write(1, 0, 16'hFFFF);
        add_write(63, GS - 1, 16'h5A5A);
        add_start(63, 16'hFFFF, 11'd5);
        add_start(0, 16'd0, 11'd2);
        add_start(1, 16'd2, 11'd1);
        add_start(2, 16'd0, 11'd0);
        add_plain(KIND_CLAIM);
        repeat (4) add_plain(KIND_TICK);
        add_plain(KIND_CLAIM);
        add_start(3, 16'hFFFF, 11'd0);
        add_plain(KIND_CLAIM);
        add_start(3, 16'd0, 11'd0);
        add_plain(KIND_TICK);
        add_plain(KIND_CLAIM);

        // An overlap of 1024 clears most ends to zero
        enter_phase(PACE_STEADY, 16'hFFFF, 16'd1024);
        repeat (RAND_STEPS) add_random_step();

        // Unity gain; park one grain behind the longest delay with an
        // oversized length, then restart it short and let it play out
        enter_phase(PACE_SEND_GAPS, 16'd4096, 16'd0);
        parked              = blank_item(KIND_START);
        parked.slot         = 6'(NG - 1);
        parked.start_delay  = 16'hFFFF;
        parked.grain_length = 11'h7FF;
        item_backlog.push_back(parked);
        add_plain(KIND_CLAIM);
        add_start(NG - 1, 16'd0, 11'd3);
        repeat (3) add_plain(KIND_TICK);
        add_plain(KIND_CLAIM);
        repeat (RAND_STEPS) add_random_step();

        // Half gain puts odd samples exactly on rounding ties
        enter_phase(PACE_RECV_STALLS, 16'd2048, 16'($urandom_range(1024)));
        repeat (RAND_STEPS) add_random_step();

        // Occupy the whole pool, claim with no idle grain, then release every
        // grain through an empty playback
        enter_phase(PACE_BOTH, 16'($urandom), 16'd17);
        for (int s = 0; s < NG; s++) add_start(s, 16'(300 + s), 11'd0);
        add_plain(KIND_CLAIM);
        for (int s = 0; s < NG; s++) add_start(s, 16'd0, 11'd0);
        add_plain(KIND_TICK);
        add_plain(KIND_CLAIM);
        repeat (RAND_STEPS) add_random_step();

        // Smallest nonzero gain
        enter_phase(PACE_STEADY, 16'd1, 16'd1000);
        repeat (RAND_STEPS) add_random_step();

        // Full gain again under sender gaps
        enter_phase(PACE_SEND_GAPS, 16'hFFFF, 16'd0);
        repeat (RAND_STEPS) add_random_step();

        // Drain, then watch a while longer for stray results
        wait_drained();
        repeat (4 * NG) @(posedge i_clk);
        if (due_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", due_results.size()));
        if (n_bad == 0)
            $display("grain_voice_mixer_core verification clean");
        else
            $display("grain_voice_mixer_core verification failed");
        $finish;
    end

    // Stop a hung run
    initial begin
        #(LIMIT_NS);
        $display("grain_voice_mixer_core verification failed");
        $finish;
    end

endmodule
